@@ hw/rtl/cdq_pkg.sv @@
// cdq_pkg: shared types and codes for the circular deque.
// Holds the operation, status, cell command and state encodings.
// No dependencies.
package cdq_pkg;

   // Operation requested by an input word
   typedef enum logic [1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_REAR  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   // Result status codes
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_EMPTY    = 2'd2;

   localparam int OCC_WIDTH    = 4;
   localparam int RESULT_WIDTH = 32;

   // Command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_REAR,
      CELL_POP_FRONT,
      CELL_POP_REAR
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

endpackage

@@ hw/rtl/cdq_cell.sv @@
// cdq_cell: one storage cell of the deque chain.
// Holds one word with its valid bit and one stage of the return lane.
// Depends on cdq_pkg.
module cdq_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cdq_pkg::cell_op_type   op,
   input  logic [DATA_WIDTH-1:0]  push_word,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic                   left_valid,
   input  logic [DATA_WIDTH-1:0]  right_data,
   input  logic                   right_valid,
   input  logic [DATA_WIDTH-1:0]  ret_in_data,
   input  logic                   ret_in_valid,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   valid,
   output logic [DATA_WIDTH-1:0]  ret_data,
   output logic                   ret_valid
);
   import cdq_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] ret_data_ff, ret_data_in;
   logic                  ret_valid_ff, ret_valid_in;
   logic                  is_last;
   logic                  is_first_free;

   // local view of where the rear of the deque sits
   assign is_last       = valid_ff && !right_valid;
   assign is_first_free = left_valid && !valid_ff;

   always_comb begin
      data_in      = data_ff;
      valid_in     = valid_ff;
      // return lane walks one cell towards the front each cycle
      ret_data_in  = ret_in_data;
      ret_valid_in = ret_in_valid;
      case (op)
         CELL_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         CELL_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         CELL_PUSH_REAR: begin
            if (is_first_free) begin
               data_in  = push_word;
               valid_in = 1'b1;
            end
         end
         CELL_POP_REAR: begin
            if (is_last) begin
               valid_in     = 1'b0;
               ret_data_in  = data_ff;
               ret_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         ret_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ret_valid_ff <= ret_valid_in;
      end
      data_ff     <= data_in;
      ret_data_ff <= ret_data_in;
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   assign ret_data  = ret_data_ff;
   assign ret_valid = ret_valid_ff;

endmodule

@@ hw/rtl/circular_deque.sv @@
// circular_deque: double-ended queue built as a chain of storage cells.
// Front entry always sits in cell 0; the rear is the last valid cell.
// Depends on cdq_pkg and cdq_cell.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------
//   req     | in        | req_valid, req_ready, req_mode, req_value
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_popped,
//           |           | rsp_occupancy
//
// Pushes, front pops and refused words load their result in the cycle they are taken.
// A rear pop holds the controller in the fetch state: the word leaves the
// last cell and walks the return lane one cell per cycle to cell 0.
// Synchronous active-high reset empties the chain at once.
// A result waits in the output register; a new word is taken in the cycle
// that register is read, and none while it is full and stalled.
module circular_deque #(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_popped,
   output logic [3:0]  rsp_occupancy
);
   import cdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data, cell_ret_data;
   logic [DEPTH-1:0]                 cell_valid, cell_ret_valid;
   logic [DEPTH-1:0][DATA_WIDTH-1:0] left_data, right_data, ret_in_data;
   logic [DEPTH-1:0]                 left_valid, right_valid, ret_in_valid;

   logic [DATA_WIDTH-1:0] push_word;
   logic [RESULT_WIDTH-1:0] front_ext, ret_ext;

   state_type   state_ff, state_in;
   cell_op_type cell_op;
   mode_type    mode;
   logic [CW-1:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [RESULT_WIDTH-1:0] rsp_popped_ff, rsp_popped_in;
   logic [OCC_WIDTH-1:0]    rsp_occ_ff, rsp_occ_in;
   logic        out_free, accept, rsp_load, fetch_start, full, empty;

   // width fitting of the pushed and returned words
   generate
      if (DATA_WIDTH <= RESULT_WIDTH) begin : g_narrow
         assign push_word = req_value[DATA_WIDTH-1:0];
         if (DATA_WIDTH < RESULT_WIDTH) begin : g_ext
            assign front_ext = {{(RESULT_WIDTH-DATA_WIDTH){cell_data[0][DATA_WIDTH-1]}},
                                cell_data[0]};
            assign ret_ext   = {{(RESULT_WIDTH-DATA_WIDTH){cell_ret_data[0][DATA_WIDTH-1]}},
                                cell_ret_data[0]};
         end else begin : g_same
            assign front_ext = cell_data[0];
            assign ret_ext   = cell_ret_data[0];
         end
      end else begin : g_wide
         assign push_word = {{(DATA_WIDTH-RESULT_WIDTH){1'b0}}, req_value};
         assign front_ext = cell_data[0][RESULT_WIDTH-1:0];
         assign ret_ext   = cell_ret_data[0][RESULT_WIDTH-1:0];
      end
      if (CW >= OCC_WIDTH) begin : g_occ_trunc
         assign rsp_occ_in = count_in[OCC_WIDTH-1:0];
      end else begin : g_occ_ext
         assign rsp_occ_in = {{(OCC_WIDTH-CW){1'b0}}, count_in};
      end
   endgenerate

   // chain of cells; the word being pushed stands left of cell 0
   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_head
            assign left_data[i]  = push_word;
            assign left_valid[i] = 1'b1;
         end else begin : g_body
            assign left_data[i]  = cell_data[i-1];
            assign left_valid[i] = cell_valid[i-1];
         end
         if (i == DEPTH - 1) begin : g_end
            assign right_data[i]   = '0;
            assign right_valid[i]  = 1'b0;
            assign ret_in_data[i]  = '0;
            assign ret_in_valid[i] = 1'b0;
         end else begin : g_mid
            assign right_data[i]   = cell_data[i+1];
            assign right_valid[i]  = cell_valid[i+1];
            assign ret_in_data[i]  = cell_ret_data[i+1];
            assign ret_in_valid[i] = cell_ret_valid[i+1];
         end
         cdq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .op           (cell_op),
            .push_word    (push_word),
            .left_data    (left_data[i]),
            .left_valid   (left_valid[i]),
            .right_data   (right_data[i]),
            .right_valid  (right_valid[i]),
            .ret_in_data  (ret_in_data[i]),
            .ret_in_valid (ret_in_valid[i]),
            .data         (cell_data[i]),
            .valid        (cell_valid[i]),
            .ret_data     (cell_ret_data[i]),
            .ret_valid    (cell_ret_valid[i])
         );
      end
   endgenerate

   assign mode     = mode_type'(req_mode);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;
   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (fetch_start) state_in = ST_FETCH;
         ST_FETCH: if (cell_ret_valid[0]) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_ready     = 1'b0;
      cell_op       = CELL_HOLD;
      rsp_load      = 1'b0;
      fetch_start   = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_popped_in = '0;
      count_in      = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (accept) begin
               rsp_load = 1'b1;
               unique case (mode)
                  MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                     if (full) begin
                        rsp_status_in = STATUS_OVERFLOW;
                     end else begin
                        cell_op  = (mode == MODE_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                             : CELL_PUSH_REAR;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cell_op       = CELL_POP_FRONT;
                        rsp_popped_in = front_ext;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  MODE_POP_REAR: begin
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // result comes back along the return lane
                        cell_op     = CELL_POP_REAR;
                        count_in    = count_ff - 1'b1;
                        rsp_load    = 1'b0;
                        fetch_start = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (cell_ret_valid[0]) begin
               rsp_load      = 1'b1;
               rsp_popped_in = ret_ext;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_popped    = rsp_popped_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

@@ test/deque_checker.sv @@
// deque_checker: watches both channels of circular_deque, predicts each result
// from its own ring store, head, tail and count, and compares field by field.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module deque_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_popped,
   input  logic [3:0]  rsp_occupancy,
   output int          fail_count,
   output int          outstanding
);
   import cdq_pkg::*;

   localparam int RING_DEPTH = 8;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] popped;
      logic [3:0]  occupancy;
   } deque_result_type;

   logic [31:0]      ring [RING_DEPTH];
   logic [2:0]       head;
   logic [2:0]       tail;
   logic [3:0]       held;
   deque_result_type awaited_results[$];

   task automatic predict_deque_op(input mode_type op, input logic [31:0] word,
                                   output deque_result_type res);
      res.status = STATUS_DONE;
      res.popped = '0;
      case (op)
         MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
            if (held == 4'(RING_DEPTH)) begin
               res.status = STATUS_OVERFLOW;
            end else begin
               // first word of an empty deque always lands in slot 0
               if (held == 4'd0) begin
                  head = '0;
                  tail = '0;
                  ring[0] = word;
               end else if (op == MODE_PUSH_FRONT) begin
                  head = head - 3'd1;
                  ring[head] = word;
               end else begin
                  tail = tail + 3'd1;
                  ring[tail] = word;
               end
               held = held + 4'd1;
            end
         end
         default: begin
            if (held == 4'd0) begin
               res.status = STATUS_EMPTY;
            end else if (op == MODE_POP_FRONT) begin
               res.popped = ring[head];
               head = head + 3'd1;
               held = held - 4'd1;
            end else begin
               res.popped = ring[tail];
               tail = tail - 3'd1;
               held = held - 4'd1;
            end
         end
      endcase
      res.occupancy = held;
   endtask

   always @(posedge clock) begin : watch
      deque_result_type want;
      if (reset) begin
         head = '0;
         tail = '0;
         held = '0;
         fail_count = 0;
         awaited_results.delete();
         outstanding <= 0;
      end else begin
         // take the request first, in case a result could appear in the same cycle
         if (req_valid && req_ready) begin
            predict_deque_op(mode_type'(req_mode), req_value, want);
            awaited_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result word with nothing outstanding");
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_popped !== want.popped) begin
                  $error("popped: expected %h, got %h", want.popped, rsp_popped);
                  fail_count++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", want.occupancy,
                         rsp_occupancy);
                  fail_count++;
               end
            end
         end
         outstanding <= awaited_results.size();
      end
   end

endmodule

@@ test/tb_circular_deque.sv @@
// tb_circular_deque: drives directed and random deque operations into
// circular_deque with random gaps and stalls; deque_checker does the checking.
// Depends on cdq_pkg, circular_deque and deque_checker.
`timescale 1ns / 1ps

module tb_circular_deque;
   import cdq_pkg::*;

   localparam int RANDOM_WORDS = 1850;
   localparam int STALL_AT     = 500;
   localparam int STALL_LEN    = 150;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_popped;
   logic [3:0]  rsp_occupancy;
   logic        steady;
   int          mismatches;
   int          outstanding;

   circular_deque #(
      .DEPTH      (8),
      .DATA_WIDTH (32)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_popped    (rsp_popped),
      .rsp_occupancy (rsp_occupancy)
   );

   deque_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_popped    (rsp_popped),
      .rsp_occupancy (rsp_occupancy),
      .fail_count    (mismatches),
      .outstanding   (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer_word(input mode_type op, input logic [31:0] word);
      while (!steady && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= op;
      req_value <= word;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // receiver: random stalls, one long hold-off, and a stall-free window
   initial begin : rsp_side
      int unsigned cyc;
      rsp_ready = 1'b0;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= STALL_AT && cyc < STALL_AT + STALL_LEN)
            rsp_ready <= 1'b0;
         else if (steady)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= 30);
      end
   end

   initial begin : stimulus
      int unsigned push_pct;
      mode_type    op;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_mode  = MODE_PUSH_FRONT;
      req_value = '0;
      steady    = 1'b0;
      push_pct  = 50;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty deque, rear push into empty, then drain it again
      offer_word(MODE_POP_FRONT,  $urandom);
      offer_word(MODE_POP_REAR,   $urandom);
      offer_word(MODE_PUSH_REAR,  32'h7FFF_FFFF);
      offer_word(MODE_POP_FRONT,  $urandom);
      // fill from both ends so the head index wraps
      offer_word(MODE_PUSH_FRONT, 32'h8000_0000);
      offer_word(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
      offer_word(MODE_PUSH_REAR,  32'h0000_0000);
      offer_word(MODE_PUSH_REAR,  32'h5555_AAAA);
      offer_word(MODE_PUSH_FRONT, 32'hAAAA_5555);
      offer_word(MODE_PUSH_REAR,  32'h0000_0001);
      offer_word(MODE_PUSH_FRONT, 32'h1234_5678);
      offer_word(MODE_PUSH_REAR,  32'hDEAD_BEEF);
      // full: both pushes refused
      offer_word(MODE_PUSH_FRONT, 32'hCAFE_F00D);
      offer_word(MODE_PUSH_REAR,  32'h0BAD_CAFE);
      // alternate pops down to the last entry and past it
      repeat (4) begin
         offer_word(MODE_POP_REAR,  $urandom);
         offer_word(MODE_POP_FRONT, $urandom);
      end
      offer_word(MODE_POP_REAR,   $urandom);
      offer_word(MODE_PUSH_FRONT, $urandom);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // swing between filling and draining so full and empty come up often
         if (n % 32 == 0) begin
            case ($urandom_range(2))
               0:       push_pct = 15;
               1:       push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         steady <= (n >= 900 && n < 1200);
         if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
         else
            op = $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
         offer_word(op, random_word());
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
